### hw/rtl/mnpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note pair matcher package
// Shared widths, codes, record types and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mnpm_pkg;

  // Table geometry
  localparam int OPEN_DEPTH = 16;
  localparam int KEY_COUNT  = 128;
  localparam int IDX_W      = $clog2(OPEN_DEPTH);
  localparam int CNT_W      = $clog2(OPEN_DEPTH + 1);

  // Field widths
  localparam int TICK_W  = 31;
  localparam int CHAN_W  = 4;
  localparam int KEY_W   = 7;
  localparam int VEL_W   = 7;
  localparam int VOL_W   = 8;
  localparam int TYPE_W  = 2;
  localparam int CTR_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(KEY_COUNT - 1);

  // Input command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  // Event type codes; anything else is a non-note event
  localparam logic [TYPE_W-1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [TYPE_W-1:0] EV_NOTE_OFF = 2'd1;

  // Result kinds
  localparam logic RK_NOTE    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MAX   = 2'd2;

  // Configuration reset values
  localparam logic [TICK_W-1:0] WINDOW_START_RST = '0;
  localparam logic [VOL_W-1:0]  VOLUME_MIN_RST   = 8'd0;
  localparam logic [VOL_W-1:0]  VOLUME_MAX_RST   = 8'd200;

  // One open note-on in the table
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [CHAN_W-1:0] chan;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  vel;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic              result_kind;
    logic [TICK_W-1:0] out_length;
    logic [TICK_W-1:0] out_position;
    logic [KEY_W-1:0]  out_key;
    logic [VOL_W-1:0]  out_volume;
    logic              last_of_run;
    logic [CTR_W-1:0]  consumed_count;
    logic [CTR_W-1:0]  skipped_count;
    logic [CTR_W-1:0]  notes_made;
    logic [CTR_W-1:0]  open_unmatched;
    logic [CTR_W-1:0]  release_unmatched;
    logic [TICK_W-1:0] window_end_tick;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;       // take the input beat
    logic event_step;    // counters, window end, insert, search
    logic rel_take;      // take the matched entry and close the gap
    logic rel_miss;      // count an unmatched release
    logic flush_init;    // latch the window end, restart the walk
    logic flush_take;    // take the next open entry of the walk
    logic emit_note;     // form a note in the output register
    logic emit_summary;  // form the summary and clear the window
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_close;
    logic is_release;
    logic hit;
    logic flush_more;
    logic sel_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/mnpm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note pair matcher channel interfaces
// Event input, result output and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface mnpm_evt_if import mnpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TYPE_W-1:0] event_type;
  logic [CHAN_W-1:0] midi_channel;
  logic [KEY_W-1:0]  event_key;
  logic [VEL_W-1:0]  event_velocity;
  logic [TICK_W-1:0] event_tick;

  modport source (output valid, command, event_type, midi_channel, event_key,
                  event_velocity, event_tick, input ready);
  modport sink   (input valid, command, event_type, midi_channel, event_key,
                  event_velocity, event_tick, output ready);
endinterface

interface mnpm_res_if import mnpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [TICK_W-1:0] out_length;
  logic [TICK_W-1:0] out_position;
  logic [KEY_W-1:0]  out_key;
  logic [VOL_W-1:0]  out_volume;
  logic              last_of_run;
  logic [CTR_W-1:0]  consumed_count;
  logic [CTR_W-1:0]  skipped_count;
  logic [CTR_W-1:0]  notes_made;
  logic [CTR_W-1:0]  open_unmatched;
  logic [CTR_W-1:0]  release_unmatched;
  logic [TICK_W-1:0] window_end_tick;

  modport source (output valid, result_kind, out_length, out_position, out_key,
                  out_volume, last_of_run, consumed_count, skipped_count,
                  notes_made, open_unmatched, release_unmatched,
                  window_end_tick, input ready);
  modport sink   (input valid, result_kind, out_length, out_position, out_key,
                  out_volume, last_of_run, consumed_count, skipped_count,
                  notes_made, open_unmatched, release_unmatched,
                  window_end_tick, output ready);
endinterface

interface mnpm_cfg_if import mnpm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/midi_note_pair_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note pair matcher
// Pairs note-ons with releases over one capture window and reports notes and
// a closing summary.
// ----------------------------------------------------------------------------
// An event beat is taken, then the table is updated, when it is a note-on with a
// velocity or a non-note event. A release that finds no open note is taken,
// updated and searched, then the miss is counted. A release that closes an
// open note is taken, updated and searched, the matched entry is read with
// the gap closed, and the note arithmetic goes into the output register,
// after which the input is ready again. A close beat is taken, the window end
// is latched, then one table read and one arithmetic step per open note run
// through the single read port, a last check that the walk is done follows,
// then the summary. The steps into the output register stall while a result
// waits unclaimed there; an item that yields no result goes ahead regardless.
// No clearing pass is needed after reset.
// Configuration writes are taken at any time and are meant to be made only
// while the block is idle.
module midi_note_pair_matcher_top import mnpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mnpm_evt_if.sink   evt_i,
  mnpm_res_if.source res_o,
  mnpm_cfg_if.sink   cfg_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign evt_i.ready = in_ready;

  // Sequencer.
  mnpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, counters and arithmetic.
  mnpm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
`default_nettype wire

### hw/rtl/mnpm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note pair matcher controller
// Sequences each input beat through table update, release matching, the
// close-time walk over open notes and the output register.
// ----------------------------------------------------------------------------
module mnpm_ctrl import mnpm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_REL  = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0] state_q, state_d;

  // Input is taken only between items.
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_close) begin
          cmd_o.flush_init = 1'b1;
          state_d          = S_FRD;
        end else begin
          cmd_o.event_step = 1'b1;
          state_d          = stat_i.is_release ? S_REL : S_IDLE;
        end
      end
      S_REL: begin
        if (stat_i.hit) begin
          cmd_o.rel_take = 1'b1;
          state_d        = S_CALC;
        end else begin
          cmd_o.rel_miss = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FRD: begin
        if (stat_i.flush_more) begin
          cmd_o.flush_take = 1'b1;
          state_d          = S_CALC;
        end else begin
          state_d = S_SUM;
        end
      end
      S_CALC: begin
        if (stat_i.out_free) begin
          cmd_o.emit_note = 1'b1;
          state_d         = stat_i.sel_last ? S_IDLE : S_FRD;
        end
      end
      S_SUM: begin
        if (stat_i.out_free) begin
          cmd_o.emit_summary = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mnpm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note pair matcher datapath
// Configuration registers, the age-ordered table of open note-ons, window
// counters, release search, note arithmetic and the output register.
// ----------------------------------------------------------------------------
module mnpm_dp import mnpm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mnpm_evt_if.sink     evt_i,
  mnpm_res_if.source   res_o,
  mnpm_cfg_if.sink     cfg_i,
  input  wire dp_cmd_t cmd_i,
  output dp_stat_t     stat_o
);

  // Saturating counter step.
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  // Configuration
  logic [TICK_W-1:0] win_start_q;
  logic [VOL_W-1:0]  vol_min_q, vol_max_q;

  // Captured input beat
  logic              cmd_q;
  logic [TYPE_W-1:0] type_q;
  logic [CHAN_W-1:0] chan_q;
  logic [KEY_W-1:0]  key_q;
  logic [VEL_W-1:0]  vel_q;
  logic [TICK_W-1:0] tick_q;

  // Table and window state
  entry_t            tab_q [OPEN_DEPTH];
  logic [CNT_W-1:0]  cnt_q;
  logic [TICK_W-1:0] max_tick_q;
  logic [CTR_W-1:0]  consumed_q, skipped_q, notes_q, open_unm_q, rel_unm_q;
  logic [TICK_W-1:0] end_q;
  logic [CNT_W-1:0]  walk_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;

  // Selected note awaiting arithmetic
  logic [TICK_W-1:0] sel_on_q, sel_off_q;
  logic [KEY_W-1:0]  sel_key_q;
  logic [VEL_W-1:0]  sel_vel_q;
  logic              sel_last_q;

  // Output register
  res_t res_q;
  logic res_valid_q;

  logic              full;
  logic              is_note;
  logic              is_press;
  logic              match_any;
  logic [IDX_W-1:0]  match_idx;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_entry;
  logic [TICK_W-1:0] win_end;
  logic              out_free;
  logic [TICK_W:0]   len_diff, pos_diff;
  logic [VOL_W-1:0]  vol_lo, vol_c;
  res_t              note_res;
  res_t              sum_res;

  assign cfg_i.ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= WINDOW_START_RST;
      vol_min_q   <= VOLUME_MIN_RST;
      vol_max_q   <= VOLUME_MAX_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WINDOW_START: win_start_q <= cfg_i.data;
        REG_VOLUME_MIN:   vol_min_q   <= cfg_i.data[VOL_W-1:0];
        REG_VOLUME_MAX:   vol_max_q   <= cfg_i.data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the captured beat.
  assign full     = (cnt_q == CNT_W'(OPEN_DEPTH));
  assign is_note  = (type_q == EV_NOTE_ON) || (type_q == EV_NOTE_OFF);
  assign is_press = (type_q == EV_NOTE_ON) && (vel_q != '0);
  assign win_end  = (max_tick_q > win_start_q) ? max_tick_q : win_start_q;
  assign out_free = !res_valid_q || res_o.ready;

  // Release search: the oldest valid entry with the same channel and key.
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = OPEN_DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt_q) && (tab_q[i].chan == chan_q) &&
          (tab_q[i].key == key_q)) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  // Single table read port: matched entry or the walk position.
  assign rd_addr  = cmd_i.rel_take ? hit_idx_q : walk_q[IDX_W-1:0];
  assign rd_entry = tab_q[rd_addr];

  // Note arithmetic: length at least one, position clamped at zero,
  // key clamped to range, volume raised to the minimum then lowered to the
  // maximum.
  assign len_diff = {1'b0, sel_off_q} - {1'b0, sel_on_q};
  assign pos_diff = {1'b0, sel_on_q} - {1'b0, win_start_q};
  assign vol_lo   = ({1'b0, sel_vel_q} < vol_min_q) ? vol_min_q : {1'b0, sel_vel_q};
  assign vol_c    = (vol_lo > vol_max_q) ? vol_max_q : vol_lo;

  always_comb begin
    note_res              = '0;
    note_res.result_kind  = RK_NOTE;
    note_res.out_length   = (len_diff[TICK_W] || (len_diff == '0)) ?
                            TICK_W'(1) : len_diff[TICK_W-1:0];
    note_res.out_position = pos_diff[TICK_W] ? '0 : pos_diff[TICK_W-1:0];
    note_res.out_key      = (sel_key_q > KEY_MAX) ? KEY_MAX : sel_key_q;
    note_res.out_volume   = vol_c;
    note_res.last_of_run  = sel_last_q;
  end

  // Summary beat of the closing window.
  always_comb begin
    sum_res                   = '0;
    sum_res.result_kind       = RK_SUMMARY;
    sum_res.last_of_run       = 1'b1;
    sum_res.consumed_count    = consumed_q;
    sum_res.skipped_count     = skipped_q;
    sum_res.notes_made        = notes_q;
    sum_res.open_unmatched    = open_unm_q;
    sum_res.release_unmatched = rel_unm_q;
    sum_res.window_end_tick   = end_q;
  end

  // Payload registers: captured beat, table contents, selected note.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= evt_i.command;
      type_q <= evt_i.event_type;
      chan_q <= evt_i.midi_channel;
      key_q  <= evt_i.event_key;
      vel_q  <= evt_i.event_velocity;
      tick_q <= evt_i.event_tick;
    end
    if (cmd_i.event_step && is_press && !full) begin
      tab_q[cnt_q[IDX_W-1:0]] <= '{tick: tick_q, chan: chan_q, key: key_q, vel: vel_q};
    end
    if (cmd_i.rel_take) begin
      for (int i = 0; i < OPEN_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= hit_idx_q) begin
          tab_q[i] <= tab_q[i + 1];
        end
      end
    end
    if (cmd_i.event_step) begin
      hit_idx_q <= match_idx;
    end
    if (cmd_i.flush_init) begin
      end_q <= win_end;
    end
    if (cmd_i.rel_take || cmd_i.flush_take) begin
      sel_on_q   <= rd_entry.tick;
      sel_key_q  <= rd_entry.key;
      sel_vel_q  <= rd_entry.vel;
      sel_off_q  <= cmd_i.rel_take ? tick_q : end_q;
    end
    if (cmd_i.emit_note) begin
      res_q <= note_res;
    end else if (cmd_i.emit_summary) begin
      res_q <= sum_res;
    end
  end

  // Window state and control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      max_tick_q  <= '0;
      consumed_q  <= '0;
      skipped_q   <= '0;
      notes_q     <= '0;
      open_unm_q  <= '0;
      rel_unm_q   <= '0;
      walk_q      <= '0;
      hit_q       <= 1'b0;
      sel_last_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.event_step) begin
        consumed_q <= sat_inc(consumed_q);
        hit_q      <= match_any;
        if (!is_note) begin
          skipped_q <= sat_inc(skipped_q);
        end else begin
          if (tick_q > max_tick_q) begin
            max_tick_q <= tick_q;
          end
          if (is_press) begin
            if (full) begin
              skipped_q <= sat_inc(skipped_q);
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
      end
      if (cmd_i.rel_miss) begin
        rel_unm_q <= sat_inc(rel_unm_q);
      end
      if (cmd_i.rel_take) begin
        cnt_q      <= cnt_q - 1'b1;
        notes_q    <= sat_inc(notes_q);
        sel_last_q <= 1'b1;
      end
      if (cmd_i.flush_init) begin
        walk_q <= '0;
      end
      if (cmd_i.flush_take) begin
        walk_q     <= walk_q + 1'b1;
        notes_q    <= sat_inc(notes_q);
        open_unm_q <= sat_inc(open_unm_q);
        sel_last_q <= 1'b0;
      end
      if (cmd_i.emit_summary) begin
        cnt_q      <= '0;
        max_tick_q <= '0;
        consumed_q <= '0;
        skipped_q  <= '0;
        notes_q    <= '0;
        open_unm_q <= '0;
        rel_unm_q  <= '0;
      end
      if (cmd_i.emit_note || cmd_i.emit_summary) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.is_close   = (cmd_q == CMD_CLOSE);
    stat_o.is_release = is_note && !is_press;
    stat_o.hit        = hit_q;
    stat_o.flush_more = (walk_q < cnt_q);
    stat_o.sel_last   = sel_last_q;
    stat_o.out_free   = out_free;
  end

  // Output beat.
  assign res_o.valid             = res_valid_q;
  assign res_o.result_kind       = res_q.result_kind;
  assign res_o.out_length        = res_q.out_length;
  assign res_o.out_position      = res_q.out_position;
  assign res_o.out_key           = res_q.out_key;
  assign res_o.out_volume        = res_q.out_volume;
  assign res_o.last_of_run       = res_q.last_of_run;
  assign res_o.consumed_count    = res_q.consumed_count;
  assign res_o.skipped_count     = res_q.skipped_count;
  assign res_o.notes_made        = res_q.notes_made;
  assign res_o.open_unmatched    = res_q.open_unmatched;
  assign res_o.release_unmatched = res_q.release_unmatched;
  assign res_o.window_end_tick   = res_q.window_end_tick;

  // The table fill never exceeds its depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OPEN_DEPTH))
    else $error("open table count beyond depth");

  // A matched entry is taken only after a successful search.
  a_take_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rel_take |-> (hit_q && (cnt_q != '0)))
    else $error("release taken without a match");

  // A new result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_note || cmd_i.emit_summary) |-> (!res_valid_q || res_o.ready))
    else $error("result register overwritten");

  // The summary leaves an empty window behind.
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_summary |=> ((cnt_q == '0) && (notes_q == '0)))
    else $error("window not cleared after summary");

endmodule
`default_nettype wire
